@@ src/console_serial_clock_interrupt_block_assert.svh @@
// Assertion macros for the console serial and line clock block.
// Used by the top level; refers to the clk and rst_n of the including module.
`ifndef CONSOLE_SERIAL_CLOCK_INTERRUPT_BLOCK_ASSERT_SVH
`define CONSOLE_SERIAL_CLOCK_INTERRUPT_BLOCK_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define CSC_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csc: same-cycle check failed");

// Next-cycle implication.
`define CSC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csc: next-cycle check failed");

`endif

@@ src/csc_pkg.sv @@
// Shared types, codes and reset constants of the console serial and line clock block.
// No dependencies.
`timescale 1ns / 1ps

package csc_pkg;

    typedef enum logic [1:0] {
        CMD_READ    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_RX_CHAR = 2'd3
    } csc_cmd_t;

    typedef enum logic [2:0] {
        SEL_RX_STATUS  = 3'd0,
        SEL_RX_BUFFER  = 3'd1,
        SEL_TX_STATUS  = 3'd2,
        SEL_TX_BUFFER  = 3'd3,
        SEL_CLK_STATUS = 3'd4
    } csc_sel_t;

    typedef enum logic [2:0] {
        CFG_CLOCK_LIMIT = 3'd0,
        CFG_TX_DELAY    = 3'd1,
        CFG_CLK_VECTOR  = 3'd2,
        CFG_CLK_LEVEL   = 3'd3,
        CFG_RX_VECTOR   = 3'd4,
        CFG_RX_LEVEL    = 3'd5,
        CFG_TX_VECTOR   = 3'd6,
        CFG_TX_LEVEL    = 3'd7
    } csc_cfg_idx_t;

    localparam int BIT_IE   = 6;
    localparam int BIT_DONE = 7;

    localparam int PEND_CLK = 0;
    localparam int PEND_RX  = 1;
    localparam int PEND_TX  = 2;

    localparam logic [15:0] CLOCK_LIMIT_RESET = 16'd8000;
    localparam logic [9:0]  TX_DELAY_RESET    = 10'd100;
    localparam logic [8:0]  CLK_VECTOR_RESET  = 9'd64;
    localparam logic [2:0]  CLK_LEVEL_RESET   = 3'd6;
    localparam logic [8:0]  RX_VECTOR_RESET   = 9'd48;
    localparam logic [2:0]  RX_LEVEL_RESET    = 3'd4;
    localparam logic [8:0]  TX_VECTOR_RESET   = 9'd52;
    localparam logic [2:0]  TX_LEVEL_RESET    = 3'd4;

    typedef struct packed {
        logic [15:0] clock_limit;
        logic [9:0]  tx_delay;
        logic [8:0]  clk_vector;
        logic [2:0]  clk_level;
        logic [8:0]  rx_vector;
        logic [2:0]  rx_level;
        logic [8:0]  tx_vector;
        logic [2:0]  tx_level;
    } csc_cfg_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  reg_select;
        logic        odd_byte;
        logic [15:0] write_data;
        logic [7:0]  rx_char;
    } csc_item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        rx_accepted;
        logic        int_request;
        logic [8:0]  int_vector;
        logic [7:0]  int_level_bits;
    } csc_result_t;

    typedef struct packed {
        logic       any;
        logic [8:0] vector;
        logic [7:0] level_bits;
    } csc_enc_t;

    function automatic logic [15:0] status_word(input logic done, input logic enable);
        return {8'h00, done, enable, 6'h00};
    endfunction

endpackage

@@ src/csc_item_if.sv @@
// Input channel of the console serial and line clock block: one bus access,
// tick or received character per item. No dependencies.
`timescale 1ns / 1ps

interface csc_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [2:0]  reg_select;
    logic        odd_byte;
    logic [15:0] write_data;
    logic [7:0]  rx_char;

    modport source (
        output valid, command, reg_select, odd_byte, write_data, rx_char,
        input  ready
    );
    modport sink (
        input  valid, command, reg_select, odd_byte, write_data, rx_char,
        output ready
    );
endinterface

@@ src/csc_result_if.sv @@
// Result channel of the console serial and line clock block: read data,
// receive status and the interrupt request. No dependencies.
`timescale 1ns / 1ps

interface csc_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic        rx_accepted;
    logic        int_request;
    logic [8:0]  int_vector;
    logic [7:0]  int_level_bits;

    modport source (
        output valid, read_data, rx_accepted, int_request, int_vector, int_level_bits,
        input  ready
    );
    modport sink (
        input  valid, read_data, rx_accepted, int_request, int_vector, int_level_bits,
        output ready
    );
endinterface

@@ src/csc_cfg_regs.sv @@
// Configuration registers: clock limit, transmit delay, vectors and levels.
// Depends on csc_pkg.
`timescale 1ns / 1ps

module csc_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output csc_pkg::csc_cfg_t  cfg
);

    csc_pkg::csc_cfg_t cfg_reg;
    csc_pkg::csc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (csc_pkg::csc_cfg_idx_t'(cfg_index))
                csc_pkg::CFG_CLOCK_LIMIT: cfg_next.clock_limit = cfg_data;
                csc_pkg::CFG_TX_DELAY:    cfg_next.tx_delay    = cfg_data[9:0];
                csc_pkg::CFG_CLK_VECTOR:  cfg_next.clk_vector  = cfg_data[8:0];
                csc_pkg::CFG_CLK_LEVEL:   cfg_next.clk_level   = cfg_data[2:0];
                csc_pkg::CFG_RX_VECTOR:   cfg_next.rx_vector   = cfg_data[8:0];
                csc_pkg::CFG_RX_LEVEL:    cfg_next.rx_level    = cfg_data[2:0];
                csc_pkg::CFG_TX_VECTOR:   cfg_next.tx_vector   = cfg_data[8:0];
                csc_pkg::CFG_TX_LEVEL:    cfg_next.tx_level    = cfg_data[2:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clock_limit <= csc_pkg::CLOCK_LIMIT_RESET;
            cfg_reg.tx_delay    <= csc_pkg::TX_DELAY_RESET;
            cfg_reg.clk_vector  <= csc_pkg::CLK_VECTOR_RESET;
            cfg_reg.clk_level   <= csc_pkg::CLK_LEVEL_RESET;
            cfg_reg.rx_vector   <= csc_pkg::RX_VECTOR_RESET;
            cfg_reg.rx_level    <= csc_pkg::RX_LEVEL_RESET;
            cfg_reg.tx_vector   <= csc_pkg::TX_VECTOR_RESET;
            cfg_reg.tx_level    <= csc_pkg::TX_LEVEL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/csc_int_enc.sv @@
// Fixed-priority interrupt encoder: clock, then receiver, then transmitter.
// Depends on csc_pkg.
`timescale 1ns / 1ps

module csc_int_enc (
    input  logic [2:0]         pending,
    input  csc_pkg::csc_cfg_t  cfg,
    output csc_pkg::csc_enc_t  enc
);

    always_comb
    begin
        enc.any        = |pending;
        enc.vector     = cfg.tx_vector;
        enc.level_bits = 8'b1 << cfg.tx_level;
        if (pending[csc_pkg::PEND_CLK])
        begin
            enc.vector     = cfg.clk_vector;
            enc.level_bits = 8'b1 << cfg.clk_level;
        end
        else if (pending[csc_pkg::PEND_RX])
        begin
            enc.vector     = cfg.rx_vector;
            enc.level_bits = 8'b1 << cfg.rx_level;
        end
    end

endmodule

@@ src/csc_core.sv @@
// Device state of the receiver, transmitter and line clock, with the update
// and result logic for one item. Depends on csc_pkg and csc_int_enc.
`timescale 1ns / 1ps

module csc_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  csc_pkg::csc_item_t    item,
    input  csc_pkg::csc_cfg_t     cfg,
    output csc_pkg::csc_result_t  result
);

    logic        rx_done_reg,   rx_done_next;
    logic        rx_enable_reg, rx_enable_next;
    logic [7:0]  rx_byte_reg,   rx_byte_next;
    logic        tx_done_reg,   tx_done_next;
    logic        tx_enable_reg, tx_enable_next;
    logic [7:0]  tx_byte_reg,   tx_byte_next;
    logic [9:0]  tx_countdown_reg, tx_countdown_next;
    logic        clk_done_reg,  clk_done_next;
    logic        clk_enable_reg, clk_enable_next;
    logic [15:0] clk_count_reg, clk_count_next;
    logic [2:0]  pending_reg,   pending_next;
    logic [8:0]  held_vector_reg, held_vector_next;
    logic [7:0]  held_level_reg,  held_level_next;

    logic [15:0] rdata;
    logic        accepted;
    logic [16:0] count_inc;
    logic [9:0]  count_dec;
    logic        new_ie;
    csc_pkg::csc_enc_t enc;

    assign new_ie    = item.write_data[csc_pkg::BIT_IE];
    assign count_inc = {1'b0, clk_count_reg} + 17'd1;
    assign count_dec = tx_countdown_reg - 10'd1;

    always_comb
    begin
        rx_done_next      = rx_done_reg;
        rx_enable_next    = rx_enable_reg;
        rx_byte_next      = rx_byte_reg;
        tx_done_next      = tx_done_reg;
        tx_enable_next    = tx_enable_reg;
        tx_byte_next      = tx_byte_reg;
        tx_countdown_next = tx_countdown_reg;
        clk_done_next     = clk_done_reg;
        clk_enable_next   = clk_enable_reg;
        clk_count_next    = clk_count_reg;
        pending_next      = pending_reg;
        rdata             = 16'h0000;
        accepted          = 1'b0;

        case (csc_pkg::csc_cmd_t'(item.command))
            csc_pkg::CMD_READ:
            begin
                case (csc_pkg::csc_sel_t'(item.reg_select))
                    csc_pkg::SEL_RX_STATUS:
                        rdata = csc_pkg::status_word(rx_done_reg, rx_enable_reg);
                    csc_pkg::SEL_RX_BUFFER:
                    begin
                        rdata = {8'h00, rx_byte_reg};
                        rx_done_next = 1'b0;
                        pending_next[csc_pkg::PEND_RX] = 1'b0;
                    end
                    csc_pkg::SEL_TX_STATUS:
                        rdata = csc_pkg::status_word(tx_done_reg, tx_enable_reg);
                    csc_pkg::SEL_TX_BUFFER:
                        rdata = {8'h00, tx_byte_reg};
                    csc_pkg::SEL_CLK_STATUS:
                        rdata = csc_pkg::status_word(clk_done_reg, clk_enable_reg);
                    default:
                        rdata = 16'h0000;
                endcase
            end
            csc_pkg::CMD_WRITE:
            begin
                case (csc_pkg::csc_sel_t'(item.reg_select))
                    csc_pkg::SEL_RX_STATUS:
                    begin
                        if (!item.odd_byte)
                        begin
                            // Raise only on the enable edge with a character waiting
                            if (!new_ie)
                                pending_next[csc_pkg::PEND_RX] = 1'b0;
                            else if (rx_done_reg && !rx_enable_reg)
                                pending_next[csc_pkg::PEND_RX] = 1'b1;
                            rx_enable_next = new_ie;
                        end
                    end
                    csc_pkg::SEL_TX_STATUS:
                    begin
                        if (!item.odd_byte)
                        begin
                            if (!new_ie)
                                pending_next[csc_pkg::PEND_TX] = 1'b0;
                            else if (tx_done_reg && !tx_enable_reg)
                                pending_next[csc_pkg::PEND_TX] = 1'b1;
                            tx_enable_next = new_ie;
                        end
                    end
                    csc_pkg::SEL_TX_BUFFER:
                    begin
                        if (!item.odd_byte)
                            tx_byte_next = item.write_data[7:0];
                        tx_done_next = 1'b0;
                        pending_next[csc_pkg::PEND_TX] = 1'b0;
                        tx_countdown_next = cfg.tx_delay;
                    end
                    csc_pkg::SEL_CLK_STATUS:
                    begin
                        if (!item.odd_byte)
                        begin
                            clk_enable_next = new_ie;
                            // A one in the done bit leaves done alone
                            if (!item.write_data[csc_pkg::BIT_DONE])
                                clk_done_next = 1'b0;
                            if (!clk_enable_next || !clk_done_next)
                                pending_next[csc_pkg::PEND_CLK] = 1'b0;
                        end
                    end
                    default:
                        rdata = 16'h0000;
                endcase
            end
            csc_pkg::CMD_TICK:
            begin
                if (count_inc > {1'b0, cfg.clock_limit})
                begin
                    clk_count_next = 16'h0000;
                    clk_done_next  = 1'b1;
                    if (clk_enable_reg)
                        pending_next[csc_pkg::PEND_CLK] = 1'b1;
                end
                else
                begin
                    clk_count_next = count_inc[15:0];
                end
                if (tx_countdown_reg != 10'd0)
                begin
                    tx_countdown_next = count_dec;
                    if (count_dec == 10'd0)
                    begin
                        tx_done_next = 1'b1;
                        if (tx_enable_reg)
                            pending_next[csc_pkg::PEND_TX] = 1'b1;
                    end
                end
            end
            csc_pkg::CMD_RX_CHAR:
            begin
                // Drop the character while the buffer is still full
                if (!rx_done_reg)
                begin
                    rx_byte_next = item.rx_char;
                    rx_done_next = 1'b1;
                    if (rx_enable_reg)
                        pending_next[csc_pkg::PEND_RX] = 1'b1;
                    accepted = 1'b1;
                end
            end
            default:
                rdata = 16'h0000;
        endcase
    end

    csc_int_enc u_int_enc (
        .pending (pending_next),
        .cfg     (cfg),
        .enc     (enc)
    );

    assign held_vector_next = enc.any ? enc.vector     : held_vector_reg;
    assign held_level_next  = enc.any ? enc.level_bits : held_level_reg;

    always_comb
    begin
        result.read_data      = rdata;
        result.rx_accepted    = accepted;
        result.int_request    = enc.any;
        result.int_vector     = held_vector_next;
        result.int_level_bits = held_level_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_done_reg      <= 1'b0;
            rx_enable_reg    <= 1'b0;
            rx_byte_reg      <= 8'h00;
            tx_done_reg      <= 1'b1;
            tx_enable_reg    <= 1'b0;
            tx_byte_reg      <= 8'h00;
            tx_countdown_reg <= 10'd0;
            clk_done_reg     <= 1'b1;
            clk_enable_reg   <= 1'b0;
            clk_count_reg    <= 16'h0000;
            pending_reg      <= 3'b000;
            held_vector_reg  <= 9'd0;
            held_level_reg   <= 8'h00;
        end
        else if (step)
        begin
            rx_done_reg      <= rx_done_next;
            rx_enable_reg    <= rx_enable_next;
            rx_byte_reg      <= rx_byte_next;
            tx_done_reg      <= tx_done_next;
            tx_enable_reg    <= tx_enable_next;
            tx_byte_reg      <= tx_byte_next;
            tx_countdown_reg <= tx_countdown_next;
            clk_done_reg     <= clk_done_next;
            clk_enable_reg   <= clk_enable_next;
            clk_count_reg    <= clk_count_next;
            pending_reg      <= pending_next;
            held_vector_reg  <= held_vector_next;
            held_level_reg   <= held_level_next;
        end
    end

endmodule

@@ src/console_serial_clock_interrupt_block.sv @@
// Top level of the console receiver, transmitter and line clock block.
// Depends on csc_pkg, csc_item_if, csc_result_if, csc_cfg_regs, csc_core
// and the assertion macro header.
//
//   channel     dir   kind            payload
//   item_in     in    valid/ready     command, reg_select, odd_byte, write_data, rx_char
//   result_out  out   valid/ready     read_data, rx_accepted, int_request, int_vector,
//                                     int_level_bits
//   cfg_*       in    write enable    cfg_index (3 bits), cfg_data (16 bits)
//
// One item per cycle sustained while result_out is ready; an item taken goes into the input
// register, then into the result register when it advances, and its result is offered from there.
// The device state updates as an item moves from the input register into the result register.
// A stalled result holds the result register; the input register still takes one item.
// rst_n is asynchronous and clears all control and device state; no clearing pass.
`timescale 1ns / 1ps

`include "console_serial_clock_interrupt_block_assert.svh"

module console_serial_clock_interrupt_block (
    input  logic               clk,
    input  logic               rst_n,
    csc_item_if.sink           item_in,
    csc_result_if.source       result_out,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    logic                  in_valid_reg;
    csc_pkg::csc_item_t    in_item_reg;
    logic                  out_valid_reg;
    csc_pkg::csc_result_t  out_result_reg;
    logic                  advance;
    csc_pkg::csc_cfg_t     cfg;
    csc_pkg::csc_result_t  core_result;

    assign advance       = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign item_in.ready = !in_valid_reg || advance;

    csc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    csc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_in.ready)
                in_valid_reg <= item_in.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.ready && item_in.valid)
        begin
            in_item_reg.command    <= item_in.command;
            in_item_reg.reg_select <= item_in.reg_select;
            in_item_reg.odd_byte   <= item_in.odd_byte;
            in_item_reg.write_data <= item_in.write_data;
            in_item_reg.rx_char    <= item_in.rx_char;
        end
        if (advance)
            out_result_reg <= core_result;
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.read_data      = out_result_reg.read_data;
    assign result_out.rx_accepted    = out_result_reg.rx_accepted;
    assign result_out.int_request    = out_result_reg.int_request;
    assign result_out.int_vector     = out_result_reg.int_vector;
    assign result_out.int_level_bits = out_result_reg.int_level_bits;

    `CSC_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_reg)
    `CSC_ASSERT_SAME(a_level_onehot, out_valid_reg && out_result_reg.int_request, $onehot(out_result_reg.int_level_bits))
    `CSC_ASSERT_SAME(a_accept_on_rx_only, advance && core_result.rx_accepted, in_item_reg.command == csc_pkg::CMD_RX_CHAR)
    `CSC_ASSERT_SAME(a_rdata_on_read_only, advance && (in_item_reg.command != csc_pkg::CMD_READ), core_result.read_data == 16'h0000)

endmodule
